FILE: rtl/core/packet_replication_destination_table_assert.svh
// Assertion macros used by the destination table sequencer.
`ifndef PACKET_REPLICATION_DESTINATION_TABLE_ASSERT_SVH
`define PACKET_REPLICATION_DESTINATION_TABLE_ASSERT_SVH

// Same-cycle implication.
`define PRDT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PRDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/prdt_pkg.sv
package prdt_pkg;

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int COUNT_W = 7;
  localparam int ENTRY_W = ADDR_W + PORT_W;

  typedef enum logic [1:0] {
    CMD_DATA   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_LIST = 2'd1,
    KIND_FWD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] dest_ip;
    logic [PORT_W-1:0] dest_port;
    logic              request_short;
  } item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic               ack_ok;
    logic [COUNT_W-1:0] active_count;
    logic [ADDR_W-1:0]  entry_ip;
    logic [PORT_W-1:0]  entry_port;
    logic               entry_valid;
    logic               last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t beat;
  } emit_t;

endpackage

FILE: rtl/core/prdt_ram.sv
module prdt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/prdt_seq.sv
module prdt_seq
  import prdt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  input  logic  out_free,
  output emit_t emit
);

  `include "packet_replication_destination_table_assert.svh"

  localparam int IW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int RAM_W = ENTRY_W + 1;

  state_t state, state_next;
  cmd_t cmd, cmd_next;
  logic [ADDR_W-1:0] key_ip, key_ip_next;
  logic [PORT_W-1:0] key_port, key_port_next;
  logic ok, ok_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] seen, seen_next;
  logic [CW-1:0] used_cnt, used_cnt_next;
  logic [CW-1:0] act_cnt, act_cnt_next;

  logic ram_we, ram_re;
  logic [IW-1:0] ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic [RAM_W-1:0] rdata;
  logic live;
  logic hit;
  logic is_list;
  logic [CW-1:0] seen_inc;
  logic [CW+COUNT_W-1:0] cnt_wide;
  logic fwd_last;

  prdt_ram #(
    .WIDTH(RAM_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(idx[IW-1:0]),
    .rdata(rdata)
  );

  assign live     = rdata[ENTRY_W];
  assign hit      = live && (rdata[ENTRY_W-1:0] == {key_ip, key_port});
  assign is_list  = (cmd == CMD_LIST);
  assign seen_inc = seen + 1'b1;
  assign cnt_wide = {{COUNT_W{1'b0}}, act_cnt};
  assign fwd_last = (seen_inc == act_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      used_cnt <= '0;
      act_cnt  <= '0;
    end else begin
      state    <= state_next;
      used_cnt <= used_cnt_next;
      act_cnt  <= act_cnt_next;
    end
    cmd      <= cmd_next;
    key_ip   <= key_ip_next;
    key_port <= key_port_next;
    ok       <= ok_next;
    idx      <= idx_next;
    seen     <= seen_next;
  end

  always_comb begin
    state_next    = state;
    cmd_next      = cmd;
    key_ip_next   = key_ip;
    key_port_next = key_port;
    ok_next       = ok;
    idx_next      = idx;
    seen_next     = seen;
    used_cnt_next = used_cnt;
    act_cnt_next  = act_cnt;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = used_cnt[IW-1:0];
    ram_wdata     = {1'b1, key_ip, key_port};
    item_ready    = 1'b0;
    emit          = '0;

    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd_next      = cmd_t'(item.command);
          key_ip_next   = item.dest_ip;
          key_port_next = item.dest_port;
          idx_next      = '0;
          seen_next     = '0;
          ok_next       = 1'b0;
          if (cmd_t'(item.command) inside {CMD_ADD, CMD_REMOVE}) begin
            state_next = item.request_short ? ST_FINAL : ST_READ;
          end else begin
            state_next = (act_cnt == '0) ? ST_FINAL : ST_READ;
          end
        end
      end

      ST_READ: begin
        if (idx == used_cnt) begin
          ok_next = 1'b0;
          if (cmd == CMD_ADD) begin
            ok_next = 1'b1;
            if (used_cnt != CW'(TABLE_DEPTH)) begin
              ram_we        = 1'b1;
              ram_waddr     = used_cnt[IW-1:0];
              ram_wdata     = {1'b1, key_ip, key_port};
              used_cnt_next = used_cnt + 1'b1;
              act_cnt_next  = act_cnt + 1'b1;
            end
          end
          state_next = ST_FINAL;
        end else begin
          ram_re     = 1'b1;
          state_next = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (!live) begin
          idx_next   = idx + 1'b1;
          state_next = ST_READ;
        end else begin
          case (cmd)
            CMD_ADD: begin
              if (hit) begin
                ok_next    = 1'b1;
                state_next = ST_FINAL;
              end else begin
                idx_next   = idx + 1'b1;
                state_next = ST_READ;
              end
            end
            CMD_REMOVE: begin
              if (hit) begin
                ram_we       = 1'b1;
                ram_waddr    = idx[IW-1:0];
                ram_wdata    = {1'b0, key_ip, key_port};
                act_cnt_next = act_cnt - 1'b1;
                ok_next      = 1'b1;
                state_next   = ST_FINAL;
              end else begin
                idx_next   = idx + 1'b1;
                state_next = ST_READ;
              end
            end
            default: begin
              emit.valid             = 1'b1;
              emit.beat.result_kind  = is_list ? KIND_LIST : KIND_FWD;
              emit.beat.active_count = is_list ? cnt_wide[COUNT_W-1:0] : '0;
              emit.beat.entry_ip     = rdata[ENTRY_W-1:PORT_W];
              emit.beat.entry_port   = rdata[PORT_W-1:0];
              emit.beat.entry_valid  = 1'b1;
              emit.beat.last         = fwd_last;
              if (out_free) begin
                seen_next  = seen_inc;
                idx_next   = idx + 1'b1;
                state_next = fwd_last ? ST_IDLE : ST_READ;
              end
            end
          endcase
        end
      end

      ST_FINAL: begin
        emit.valid = 1'b1;
        case (cmd)
          CMD_ADD, CMD_REMOVE: emit.beat.result_kind = KIND_ACK;
          CMD_LIST:            emit.beat.result_kind = KIND_LIST;
          default:             emit.beat.result_kind = KIND_FWD;
        endcase
        emit.beat.ack_ok = ok;
        emit.beat.last   = 1'b1;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `PRDT_ASSERT_NOW(a_active_le_used, clk, rst, 1'b1, act_cnt <= used_cnt, "active count above used slots")
  `PRDT_ASSERT_NOW(a_used_bound, clk, rst, 1'b1, used_cnt <= CW'(TABLE_DEPTH), "used slots above table depth")
  `PRDT_ASSERT_NOW(a_read_used, clk, rst, ram_re, idx < used_cnt, "read of an unused slot")
  `PRDT_ASSERT_NOW(a_no_rw_overlap, clk, rst, ram_we, !ram_re, "read and write in the same cycle")
  `PRDT_ASSERT_NEXT(a_final_done, clk, rst, (state == ST_FINAL) && out_free, state == ST_IDLE, "final beat did not return to idle")

endmodule

FILE: rtl/core/packet_replication_destination_table.sv
// Channel  Direction  Handshake                    Payload
// item     in         item_valid / item_ready      item_t
// result   out        result_valid / result_ready  result_t
//
// One item at a time; item_ready is high only while the sequencer is idle.
// Each used slot is visited by a RAM read, then a check or emit.
// Add/remove: the used slots are scanned (skipped when request_short is set) before the acknowledge, then idle.
// List/data: one beat per active entry, or a single final beat if none is active, then idle.
// A stalled result holds the sequencer on its current beat; one result register decouples.
// Reset clears the counters; slots at or above the used count are never read.
module packet_replication_destination_table
  import prdt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  emit_t emit;
  logic  out_free;

  assign out_free = !result_valid || result_ready;

  prdt_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .out_free  (out_free),
    .emit      (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= emit.valid;
    end
    if (out_free && emit.valid) begin
      result <= emit.beat;
    end
  end

endmodule
